// ----- rtl/core/velocity_acceleration_differencer_assert.svh -----
// assertion macros shared by the rtl
`ifndef VELOCITY_ACCELERATION_DIFFERENCER_ASSERT_SVH
`define VELOCITY_ACCELERATION_DIFFERENCER_ASSERT_SVH

// same-cycle implication, off during reset
`define VAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define VAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/vad_pkg.sv -----
package vad_pkg;

    localparam int DATA_WIDTH_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_LOAD,
        S_DIV,
        S_FIN,
        S_ANUM,
        S_DONE
    } t_state;

endpackage

// ----- rtl/core/velocity_acceleration_differencer.sv -----
// channel  | dir | tdata (low bit up)                 | tuser
// s_axis   | in  | sample_time, sample_position, pad  | -
// m_axis   | out | velocity, acceleration, pad        | saturated
//
// one sample at a time; a sample with a previous sample and nonzero time step
// is divided twice, for velocity and then acceleration, by the restoring
// divider that produces one quotient bit per cycle;
// other samples skip the divider
// i_rst_n is synchronous, active low, and clears the sample history
// the result register frees the input side; a stalled m_axis holds the
// finished sample in its last state until the result register empties
module velocity_acceleration_differencer
    import vad_pkg::*;
#(
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int TDW          = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [TDW-1:0] i_s_axis_tdata,   // sample_time, sample_position, zero pad
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [TDW-1:0] o_m_axis_tdata,   // velocity, acceleration, zero pad
    output logic           o_m_axis_tuser    // saturated
);

    localparam int DW  = DATA_WIDTH;
    localparam int NW  = DW + 1 + FRACTION_BITS;
    localparam int CW  = (NW > 1) ? $clog2(NW) : 1;

    t_state r_state, n_state;

    logic [DW-1:0]  r_time, r_pos;
    logic [DW-1:0]  r_prev_time, r_prev_pos, r_prev_vel;
    logic           r_have_prev;
    logic [DW:0]    r_dt, r_num;
    logic [NW-1:0]  r_dvd;
    logic [DW:0]    r_den;
    logic [DW+1:0]  r_rem;
    logic [DW-1:0]  r_quo;
    logic           r_big, r_neg, r_phase;
    logic [CW-1:0]  r_cnt;
    logic [DW-1:0]  r_vel, r_acc;
    logic           r_sat;

    logic           r_out_valid;
    logic [DW-1:0]  r_out_vel, r_out_acc;
    logic           r_out_sat;

    logic           in_accept, out_free, skip;
    logic [DW:0]    num_mag, dt_mag;
    logic [DW+1:0]  rem_shift;
    logic           rem_ge;
    logic           over;
    logic [DW-1:0]  limit, quo_mag, quo_res;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_DIFF;
            end
            S_DIFF: n_state = S_LOAD;
            S_LOAD: begin
                if (!r_phase && skip) n_state = S_DONE;
                else                  n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_FIN;
            end
            S_FIN: begin
                if (r_phase) n_state = S_DONE;
                else         n_state = S_ANUM;
            end
            S_ANUM: n_state = S_LOAD;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_axis_tready = 1'b1;
            default: o_s_axis_tready = 1'b0;
        endcase
    end

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign skip      = !r_have_prev || (r_dt == '0);

    assign num_mag   = r_num[DW] ? (~r_num + 1'b1) : r_num;
    assign dt_mag    = r_dt[DW] ? (~r_dt + 1'b1) : r_dt;

    assign rem_shift = {r_rem[DW:0], r_dvd[NW-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_den};

    assign limit   = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    assign over    = r_big || (r_quo[DW-1] && (!r_neg || (|r_quo[DW-2:0])));
    assign quo_mag = over ? limit : r_quo;
    assign quo_res = r_neg ? (~quo_mag + 1'b1) : quo_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_prev_time <= '0;
            r_prev_pos  <= '0;
            r_prev_vel  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_prev_time <= r_time;
                r_prev_pos  <= r_pos;
                r_prev_vel  <= r_vel;
                r_have_prev <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_time <= i_s_axis_tdata[DW-1:0];
            r_pos  <= i_s_axis_tdata[2*DW-1:DW];
        end
        unique case (r_state)
            S_DIFF: begin
                r_dt    <= {r_time[DW-1], r_time} - {r_prev_time[DW-1], r_prev_time};
                r_num   <= {r_pos[DW-1], r_pos} - {r_prev_pos[DW-1], r_prev_pos};
                r_vel   <= '0;
                r_acc   <= '0;
                r_sat   <= 1'b0;
                r_phase <= 1'b0;
            end
            S_LOAD: begin
                r_dvd <= NW'(num_mag) << FRACTION_BITS;
                r_den <= dt_mag;
                r_neg <= r_num[DW] ^ r_dt[DW];
                r_rem <= '0;
                r_quo <= '0;
                r_big <= 1'b0;
                r_cnt <= CW'(NW - 1);
            end
            S_DIV: begin
                r_dvd <= r_dvd << 1;
                r_rem <= rem_ge ? (rem_shift - {1'b0, r_den}) : rem_shift;
                r_quo <= {r_quo[DW-2:0], rem_ge};
                r_big <= r_big | r_quo[DW-1];
                r_cnt <= r_cnt - 1'b1;
            end
            S_FIN: begin
                r_sat <= r_sat | over;
                if (r_phase) r_acc <= quo_res;
                else         r_vel <= quo_res;
            end
            S_ANUM: begin
                r_num   <= {r_vel[DW-1], r_vel} - {r_prev_vel[DW-1], r_prev_vel};
                r_phase <= 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_vel <= r_vel;
                    r_out_acc <= r_acc;
                    r_out_sat <= r_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_sat;

    generate
        if (TDW > 2 * DW) begin : g_pad
            assign o_m_axis_tdata = {{(TDW - 2 * DW){1'b0}}, r_out_acc, r_out_vel};
        end else begin : g_nopad
            assign o_m_axis_tdata = {r_out_acc, r_out_vel};
        end
    endgenerate

    `include "velocity_acceleration_differencer_assert.svh"

    `VAD_ASSERT_NEXT(a_accept_diff, i_clk, i_rst_n, in_accept, r_state == S_DIFF, "accept did not start differencing")
    `VAD_ASSERT_NOW(a_rem_below_den, i_clk, i_rst_n, r_state == S_DIV, r_rem < {1'b0, r_den}, "remainder not below divisor")
    `VAD_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt == '0), r_state == S_FIN, "division did not finish")
    `VAD_ASSERT_NOW(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE, "result shown outside done")

endmodule
